/* sv/bads_pkg.sv */
package bads_pkg;

  // Parameter defaults
  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned MAX_FACTOR_DEF = 16;

  // Fixed height limit and channel count
  localparam int unsigned HEIGHT_LIMIT = 4096;
  localparam int unsigned CHANNELS     = 3;

  // Queue word field widths, sized for the largest parameter values
  localparam int unsigned SLOT_W = 14;
  localparam int unsigned CNT_W  = 14;
  localparam int unsigned POS_W  = 12;

  // Configuration register indexes
  localparam logic [2:0] CFG_TILE_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_TILE_HEIGHT  = 3'd1;
  localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_COLOR_MODE   = 3'd4;

  // Configuration as seen by the front part
  typedef struct packed {
    logic [4:0]  tile_width;
    logic [4:0]  tile_height;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        color_mode;
  } cfg_t;

  // One classified pixel passed from front to back
  typedef struct packed {
    logic [7:0]        px_a;
    logic [7:0]        px_b;
    logic [7:0]        px_c;
    logic [SLOT_W-1:0] slot;
    logic              first;
    logic              emit;
    logic              frame_end;
    logic              rgb;
    logic [CNT_W-1:0]  count;
    logic [POS_W-1:0]  out_col;
    logic [POS_W-1:0]  out_row;
  } item_t;

endpackage

/* sv/box_average_downscaler_unit.sv */
// Box-average image downscaler.
// Input channel: in_valid_i/in_ready_o with sample_a_i..sample_c_i, one pixel
// per word in raster order (mono uses sample_a_i only).
// Output channel: out_valid_o/out_ready_i with the rounded tile averages and
// the output column, row and frame_last flag; one word per finished tile.
// Config channel: cfg_valid_i/cfg_ready_o, cfg_index_i selects tile_width,
// tile_height, image_width, image_height or color_mode; write only while idle.
// Each pixel passes the back part as a store read, then an update.
// A pixel that closes a tile also runs a bit-serial restoring divide, one
// quotient bit per cycle, and holds the back part until its word is loaded
// into the output register.
// A two-word queue between the front counters and the back datapath lets
// the input take words while the back part works or the output is stalled.
// Reset clears positions and control; the column sum store is not cleared:
// each band starts by overwriting its entries. A stalled receiver holds the
// output word, then the back part and finally the input stall in turn.
module box_average_downscaler_unit #(
  parameter int unsigned MAX_WIDTH  = bads_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_FACTOR = bads_pkg::MAX_FACTOR_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  sample_a_i,
  input  logic [7:0]  sample_b_i,
  input  logic [7:0]  sample_c_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  average_a_o,
  output logic [7:0]  average_b_o,
  output logic [7:0]  average_c_o,
  output logic [11:0] out_column_o,
  output logic [11:0] out_row_o,
  output logic        frame_last_o
);

  bads_pkg::cfg_t  cfg_q;
  bads_pkg::item_t front_item, q_item;
  logic            q_full, q_valid, q_pop, fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full;
  assign fire        = in_valid_i && in_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tile_width   <= 5'd2;
      cfg_q.tile_height  <= 5'd2;
      cfg_q.image_width  <= 13'd640;
      cfg_q.image_height <= 13'd480;
      cfg_q.color_mode   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bads_pkg::CFG_TILE_WIDTH:   cfg_q.tile_width   <= cfg_data_i[4:0];
        bads_pkg::CFG_TILE_HEIGHT:  cfg_q.tile_height  <= cfg_data_i[4:0];
        bads_pkg::CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data_i;
        bads_pkg::CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data_i;
        bads_pkg::CFG_COLOR_MODE:   cfg_q.color_mode   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  bads_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_FACTOR(MAX_FACTOR)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .fire_i    (fire),
    .sample_a_i(sample_a_i),
    .sample_b_i(sample_b_i),
    .sample_c_i(sample_c_i),
    .item_o    (front_item)
  );

  bads_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fire),
    .item_i (front_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .item_o (q_item)
  );

  bads_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_FACTOR(MAX_FACTOR)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .average_a_o (average_a_o),
    .average_b_o (average_b_o),
    .average_c_o (average_c_o),
    .out_column_o(out_column_o),
    .out_row_o   (out_row_o),
    .frame_last_o(frame_last_o)
  );

endmodule

/* sv/bads_ram.sv */
module bads_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* sv/bads_queue.sv */
module bads_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bads_pkg::item_t   item_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output bads_pkg::item_t   item_o
);

  bads_pkg::item_t entry_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      fill_q;

  assign full_o  = (fill_q == 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign item_o  = entry_q[rd_ptr_q];

  // Store words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i)      fill_q <= fill_q + 2'd1;
      else if (pop_i && !push_i) fill_q <= fill_q - 2'd1;
    end
  end

endmodule

/* sv/bads_front.sv */
module bads_front #(
  parameter int unsigned MAX_WIDTH  = bads_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_FACTOR = bads_pkg::MAX_FACTOR_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bads_pkg::cfg_t  cfg_i,
  input  logic            fire_i,
  input  logic [7:0]      sample_a_i,
  input  logic [7:0]      sample_b_i,
  input  logic [7:0]      sample_c_i,
  output bads_pkg::item_t item_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned PW = $clog2(MAX_FACTOR);

  logic [CW-1:0]  in_col_q, out_col_q;
  logic [11:0]    in_row_q, out_row_q;
  logic [PW-1:0]  col_ph_q, row_ph_q;

  logic [7:0]     tw, th;
  logic [15:0]    w, h;
  logic           tile_col_end, tile_row_end, row_end, frame_end, rgb;
  logic [2*PW+1:0] n;
  logic [CW+11:0] col_ext;

  // Clamp registers to their legal ranges
  always_comb begin
    tw = 8'(cfg_i.tile_width);
    if (tw == 8'd0) tw = 8'd1;
    else if (tw > 8'(MAX_FACTOR)) tw = 8'(MAX_FACTOR);
    th = 8'(cfg_i.tile_height);
    if (th == 8'd0) th = 8'd1;
    else if (th > 8'(MAX_FACTOR)) th = 8'(MAX_FACTOR);
    w = 16'(cfg_i.image_width);
    if (w == 16'd0) w = 16'd1;
    else if (w > 16'(MAX_WIDTH)) w = 16'(MAX_WIDTH);
    h = 16'(cfg_i.image_height);
    if (h == 16'd0) h = 16'd1;
    else if (h > 16'(bads_pkg::HEIGHT_LIMIT)) h = 16'(bads_pkg::HEIGHT_LIMIT);
  end

  // Classify the current pixel
  assign row_end      = (16'(in_col_q) + 16'd1) >= w;
  assign tile_col_end = ((8'(col_ph_q) + 8'd1) >= tw) || row_end;
  assign tile_row_end = ((8'(row_ph_q) + 8'd1) >= th) || ((16'(in_row_q) + 16'd1) >= h);
  assign frame_end    = row_end && ((16'(in_row_q) + 16'd1) >= h);
  assign rgb          = cfg_i.color_mode;
  assign n            = (2*PW+2)'((PW+1)'(col_ph_q) + (PW+1)'(1)) *
                        (2*PW+2)'((PW+1)'(row_ph_q) + (PW+1)'(1));
  assign col_ext      = (CW+12)'(out_col_q);

  always_comb begin
    item_o.px_a      = sample_a_i;
    item_o.px_b      = rgb ? sample_b_i : 8'd0;
    item_o.px_c      = rgb ? sample_c_i : 8'd0;
    item_o.slot      = bads_pkg::SLOT_W'(out_col_q);
    item_o.first     = (row_ph_q == '0) && (col_ph_q == '0);
    item_o.emit      = tile_col_end && tile_row_end;
    item_o.frame_end = frame_end;
    item_o.rgb       = rgb;
    item_o.count     = bads_pkg::CNT_W'(n);
    item_o.out_col   = col_ext[11:0];
    item_o.out_row   = out_row_q;
  end

  // Advance raster position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      col_ph_q  <= '0;
      row_ph_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (fire_i) begin
      if (frame_end) begin
        in_col_q  <= '0;
        in_row_q  <= '0;
        col_ph_q  <= '0;
        row_ph_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
      end else if (row_end) begin
        in_col_q  <= '0;
        col_ph_q  <= '0;
        out_col_q <= '0;
        in_row_q  <= in_row_q + 12'd1;
        if (tile_row_end) begin
          row_ph_q  <= '0;
          out_row_q <= out_row_q + 12'd1;
        end else begin
          row_ph_q <= row_ph_q + PW'(1);
        end
      end else begin
        in_col_q <= in_col_q + CW'(1);
        if (tile_col_end) begin
          col_ph_q  <= '0;
          out_col_q <= out_col_q + CW'(1);
        end else begin
          col_ph_q <= col_ph_q + PW'(1);
        end
      end
    end
  end

endmodule

/* sv/bads_back.sv */
module bads_back #(
  parameter int unsigned MAX_WIDTH  = bads_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_FACTOR = bads_pkg::MAX_FACTOR_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  bads_pkg::item_t q_item_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      average_a_o,
  output logic [7:0]      average_b_o,
  output logic [7:0]      average_c_o,
  output logic [11:0]     out_column_o,
  output logic [11:0]     out_row_o,
  output logic            frame_last_o
);

  localparam int unsigned CW        = $clog2(MAX_WIDTH);
  localparam int unsigned SUM_LIMIT = MAX_FACTOR * MAX_FACTOR * 255;
  localparam int unsigned SW        = $clog2(SUM_LIMIT + MAX_FACTOR * MAX_FACTOR + 256);
  localparam int unsigned NW        = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
  localparam int unsigned KW        = $clog2(SW + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_SEND = 2'd3;

  logic [1:0]      state_q;
  bads_pkg::item_t item_q;
  logic [KW-1:0]   cnt_q;
  logic [SW-1:0]   num_q [3];
  logic [NW-1:0]   rem_q [3];
  logic [SW-1:0]   quo_q [3];

  logic [3*SW-1:0] rdata;
  logic [SW-1:0]   sum_c [3];
  logic [7:0]      px [3];
  logic [NW:0]     trial [3];
  logic [NW:0]     divisor;
  logic            load_out;
  logic [7:0]      avg [3];

  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;
  assign load_out = (state_q == ST_SEND) && (!out_valid_o || out_ready_i);
  assign divisor  = (NW+1)'(item_q.count);
  assign px[0]    = item_q.px_a;
  assign px[1]    = item_q.px_b;
  assign px[2]    = item_q.px_c;

  // Column sum store
  bads_ram #(
    .WIDTH(3 * SW),
    .DEPTH(MAX_WIDTH)
  ) u_sums (
    .clk_i  (clk_i),
    .we_i   (state_q == ST_READ),
    .waddr_i(item_q.slot[CW-1:0]),
    .wdata_i({sum_c[2], sum_c[1], sum_c[0]}),
    .re_i   (q_pop_o),
    .raddr_i(q_item_i.slot[CW-1:0]),
    .rdata_o(rdata)
  );

  // Accumulate and saturate
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_c[k] = (item_q.first ? SW'(0) : rdata[k*SW +: SW]) + SW'(px[k]);
      if (sum_c[k] > SW'(SUM_LIMIT)) sum_c[k] = SW'(SUM_LIMIT);
    end
  end

  // Trial remainder for one restoring divide step per channel
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      trial[k] = {rem_q[k], num_q[k][SW-1]};
    end
  end

  // Clip the rounded quotients to 8 bits
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      avg[k] = (quo_q[k] > SW'(255)) ? 8'd255 : quo_q[k][7:0];
    end
  end

  // Sequence read, update, divide and hand-off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: if (q_valid_i) state_q <= ST_READ;
        ST_READ: begin
          cnt_q   <= '0;
          state_q <= item_q.emit ? ST_DIV : ST_IDLE;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + KW'(1);
          if (cnt_q == KW'(SW - 1)) state_q <= ST_SEND;
        end
        ST_SEND: if (load_out) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) item_q <= q_item_i;
    for (int k = 0; k < 3; k++) begin
      if (state_q == ST_READ) begin
        num_q[k] <= sum_c[k] + SW'(item_q.count >> 1);
        rem_q[k] <= '0;
        quo_q[k] <= '0;
      end else if (state_q == ST_DIV) begin
        num_q[k] <= {num_q[k][SW-2:0], 1'b0};
        if (trial[k] >= divisor) begin
          rem_q[k] <= NW'(trial[k] - divisor);
          quo_q[k] <= {quo_q[k][SW-2:0], 1'b1};
        end else begin
          rem_q[k] <= NW'(trial[k]);
          quo_q[k] <= {quo_q[k][SW-2:0], 1'b0};
        end
      end
    end
  end

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (load_out) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      average_a_o  <= avg[0];
      average_b_o  <= item_q.rgb ? avg[1] : 8'd0;
      average_c_o  <= item_q.rgb ? avg[2] : 8'd0;
      out_column_o <= item_q.out_col;
      out_row_o    <= item_q.out_row;
      frame_last_o <= item_q.frame_end;
    end
  end

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> cnt_q < KW'(SW))
    else $error("divide counter overran");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> state_q == ST_READ)
    else $error("pop did not start a read");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !load_out)
    else $error("output word overwritten");

endmodule
